@@ rtl/mri_pkg.sv @@
package mri_pkg;

    // field widths of the ports
    localparam int CH_W     = 8;
    localparam int START_W  = 10;
    localparam int LENGTH_W = 11;

    // default string capacity
    localparam int MAX_LEN_DEF = 1024;

    typedef enum logic [1:0] {
        S_LOAD,
        S_CHECK,
        S_READ,
        S_CMP
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic rd;
        logic cmp;
        logic finish;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic cand_ok;
        logic equal;
        logic full_match;
    } t_dp_status;

endpackage

@@ rtl/minimal_rotation_index.sv @@
// minimal_rotation_index: start of the lexicographically smallest rotation
// of a byte string.
// input channel: a character transaction is accepted on a rising edge with
// start high and busy low; i_ch is the byte and i_last marks the final one.
// every accepted transaction loads a character; those past MAX_LEN are dropped
// and flagged through o_too_long, a dropped last character still ends the string.
// after the last character busy rises and the two-candidate search runs over
// the character memory: each character comparison reads both candidates'
// characters, then compares them; after a mismatch the candidate check
// doubles as the read.
// output channel: one result transaction per string, o_valid high for exactly
// one cycle, starting at the edge where busy falls; the receiver cannot stall it.
// a new string may start in the same cycle as the result strobe.
// reset (synchronous, active low) returns to loading with an empty string;
// memory contents are not cleared and need no clearing pass.
module minimal_rotation_index #(
    parameter int MAX_LEN = mri_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mri_pkg::CH_W-1:0]     i_ch,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic [mri_pkg::START_W-1:0]  o_start_index,
    output logic [mri_pkg::LENGTH_W-1:0] o_str_length,
    output logic                         o_too_long
);
    import mri_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: loading, candidate check, read, compare
    mri_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_last),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // character memory, candidates, match length and result registers
    mri_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_ch          (i_ch),
        .o_status      (dp_status),
        .o_valid       (o_valid),
        .o_start_index (o_start_index),
        .o_str_length  (o_str_length),
        .o_too_long    (o_too_long)
    );

endmodule

@@ rtl/mri_ctrl.sv @@
module mri_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_last,
    input  mri_pkg::t_dp_status i_status,
    output mri_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy
);
    import mri_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_status.cand_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CMP;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_status.full_match) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_LOAD;
                end else if (i_status.equal) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_CHECK;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

    // a compare always follows a memory read
    a_cmp_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> $past(o_cmd.rd))
        else $error("compare without a preceding read");

    // a read and a finish never coincide
    a_rd_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd && o_cmd.finish))
        else $error("read and finish in the same cycle");

    // characters are only written while loading
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy)
        else $error("load while busy");

endmodule

@@ rtl/mri_dp.sv @@
module mri_dp #(
    parameter int MAX_LEN = mri_pkg::MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mri_pkg::t_dp_cmd             i_cmd,
    input  logic [mri_pkg::CH_W-1:0]     i_ch,
    output mri_pkg::t_dp_status          o_status,
    output logic                         o_valid,
    output logic [mri_pkg::START_W-1:0]  o_start_index,
    output logic [mri_pkg::LENGTH_W-1:0] o_str_length,
    output logic                         o_too_long
);
    import mri_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int CAND_W = $clog2(2 * MAX_LEN);

    logic [CH_W-1:0]     r_mem [MAX_LEN];
    logic [CH_W-1:0]     r_rd_a;
    logic [CH_W-1:0]     r_rd_b;

    logic [LEN_W-1:0]    r_count;
    logic                r_overflow;
    logic [CAND_W-1:0]   r_cand_a;
    logic [CAND_W-1:0]   r_cand_b;
    logic [LEN_W-1:0]    r_match;

    logic                r_valid;
    logic [START_W-1:0]  r_start;
    logic [LENGTH_W-1:0] r_length;
    logic                r_too_long;

    logic                room;
    logic [CAND_W-1:0]   len_c;
    logic [CAND_W-1:0]   sum_a;
    logic [CAND_W-1:0]   sum_b;
    logic [CAND_W-1:0]   wrap_a;
    logic [CAND_W-1:0]   wrap_b;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
    logic [LEN_W-1:0]    match_inc;
    logic                equal;
    logic                full_match;
    logic [CAND_W-1:0]   jump_a;
    logic [CAND_W-1:0]   jump_b;
    logic [CAND_W-1:0]   min_cand;

    assign room   = (r_count < LEN_W'(MAX_LEN));
    assign len_c  = CAND_W'(r_count);

    // wrapped offsets, one subtraction each since both terms are below the length
    assign sum_a  = r_cand_a + CAND_W'(r_match);
    assign sum_b  = r_cand_b + CAND_W'(r_match);
    assign wrap_a = (sum_a >= len_c) ? (sum_a - len_c) : sum_a;
    assign wrap_b = (sum_b >= len_c) ? (sum_b - len_c) : sum_b;
    assign addr_a = wrap_a[ADDR_W-1:0];
    assign addr_b = wrap_b[ADDR_W-1:0];

    assign match_inc  = r_match + LEN_W'(1);
    assign equal      = (r_rd_a == r_rd_b);
    assign full_match = equal && (match_inc == r_count);

    assign jump_a   = sum_a + CAND_W'(1);
    assign jump_b   = sum_b + CAND_W'(1);
    assign min_cand = (r_cand_a < r_cand_b) ? r_cand_a : r_cand_b;

    assign o_status.cand_ok    = (r_cand_a < len_c) && (r_cand_b < len_c);
    assign o_status.equal      = equal;
    assign o_status.full_match = full_match;

    // character store, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && room) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_ch;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_mem[addr_a];
            r_rd_b <= r_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_cand_a   <= '0;
            r_cand_b   <= CAND_W'(1);
            r_match    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_count    <= '0;
                r_overflow <= 1'b0;
                r_cand_a   <= '0;
                r_cand_b   <= CAND_W'(1);
                r_match    <= '0;
            end else begin
                if (i_cmd.load) begin
                    if (room) begin
                        r_count <= r_count + LEN_W'(1);
                    end else begin
                        r_overflow <= 1'b1;
                    end
                end
                if (i_cmd.cmp) begin
                    if (equal) begin
                        r_match <= match_inc;
                    end else begin
                        r_match <= '0;
                        if (r_rd_a > r_rd_b) begin
                            r_cand_a <= (jump_a > r_cand_b) ? jump_a
                                                            : r_cand_b + CAND_W'(1);
                        end else begin
                            r_cand_b <= (jump_b > r_cand_a) ? jump_b
                                                            : r_cand_a + CAND_W'(1);
                        end
                    end
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_start    <= START_W'(min_cand);
            r_length   <= LENGTH_W'(r_count);
            r_too_long <= r_overflow;
        end
    end

    assign o_valid       = r_valid;
    assign o_start_index = r_start;
    assign o_str_length  = r_length;
    assign o_too_long    = r_too_long;

    // the two candidates never coincide
    a_cand_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cand_a != r_cand_b)
        else $error("candidates coincide");

    // reads stay inside the stored string
    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (LEN_W'(addr_a) < r_count) && (LEN_W'(addr_b) < r_count))
        else $error("read beyond the stored string");

    // a finished search leaves the string state cleared
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_count == '0) && !r_overflow && (r_match == '0))
        else $error("string state not cleared after a result");

endmodule
